// ----- rtl/core/wftc_pkg.sv -----
// ---------------------------------------------------------------------
// wftc_pkg
// Shared codes, widths and helpers of the window threshold counter.
// ---------------------------------------------------------------------
package wftc_pkg;

    localparam int FIELD_W     = 10;
    localparam int COUNT_W     = 11;
    localparam int QUEUE_DEPTH = 4;

    localparam int DEF_ARRAY_DEPTH = 1024;
    localparam int DEF_VALUE_COUNT = 1024;

    localparam logic [COUNT_W-1:0] CNT_MAX = {COUNT_W{1'b1}};

    // request kinds on the input channel
    localparam logic [1:0] KIND_LOAD  = 2'd0;
    localparam logic [1:0] KIND_QUERY = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;

    // internal command codes between front and back
    typedef logic [1:0] op_t;
    localparam op_t OP_LOAD  = 2'd0;
    localparam op_t OP_QUERY = 2'd1;
    localparam op_t OP_CLEAR = 2'd2;
    localparam op_t OP_BAD   = 2'd3;

    localparam int OP_W = 2;

    function automatic int addr_w(input int depth);
        return $clog2(depth);
    endfunction

    // command word: {op, position a, window end, value}
    function automatic int cmd_w(input int array_depth, input int value_count);
        return OP_W + 2 * $clog2(array_depth) + 1 + $clog2(value_count);
    endfunction

endpackage

// ----- rtl/core/wftc_front.sv -----
// ---------------------------------------------------------------------
// wftc_front
// Takes requests, clamps range right and value, classifies them and
// packs a command word for the back end.
// ---------------------------------------------------------------------
module wftc_front #(
    parameter int ARRAY_DEPTH = wftc_pkg::DEF_ARRAY_DEPTH,
    parameter int VALUE_COUNT = wftc_pkg::DEF_VALUE_COUNT
) (
    input  logic                                    push,
    output logic                                    full,
    input  logic [1:0]                              kind,
    input  logic [wftc_pkg::FIELD_W-1:0]            element_index,
    input  logic [wftc_pkg::FIELD_W-1:0]            element_value,
    input  logic [wftc_pkg::FIELD_W-1:0]            range_left,
    input  logic [wftc_pkg::FIELD_W-1:0]            range_right,
    output logic                                    q_push,
    input  logic                                    q_full,
    output logic [wftc_pkg::cmd_w(ARRAY_DEPTH, VALUE_COUNT)-1:0] q_data
);

    localparam int AW    = wftc_pkg::addr_w(ARRAY_DEPTH);
    localparam int PW    = AW + 1;
    localparam int VAL_W = wftc_pkg::addr_w(VALUE_COUNT);
    localparam int EW    = (PW > wftc_pkg::FIELD_W) ? PW : wftc_pkg::FIELD_W;
    localparam int VX    = (VAL_W + 1 > wftc_pkg::FIELD_W) ? VAL_W + 1 : wftc_pkg::FIELD_W;

    logic [EW-1:0]    right_e;
    logic [EW-1:0]    right_c;
    logic [EW-1:0]    left_e;
    logic [EW-1:0]    idx_e;
    logic [EW-1:0]    end_e;
    logic [VX-1:0]    val_e;
    logic [VX-1:0]    val_c;
    logic             bad;
    logic             keep;
    wftc_pkg::op_t    op;
    logic [AW-1:0]    pos_a;

    always_comb
    begin
        right_e = EW'(range_right);
        left_e  = EW'(range_left);
        idx_e   = EW'(element_index);
        val_e   = VX'(element_value);
        right_c = (right_e > EW'(ARRAY_DEPTH - 1)) ? EW'(ARRAY_DEPTH - 1) : right_e;
        end_e   = right_c + EW'(1);
        val_c   = (val_e > VX'(VALUE_COUNT - 1)) ? VX'(VALUE_COUNT - 1) : val_e;
        bad     = left_e > right_c;

        keep  = 1'b0;
        op    = wftc_pkg::OP_LOAD;
        pos_a = AW'(idx_e);
        case (kind)
            wftc_pkg::KIND_LOAD:
            begin
                // loads beyond the array are dropped
                keep  = idx_e < EW'(ARRAY_DEPTH);
                op    = wftc_pkg::OP_LOAD;
                pos_a = AW'(idx_e);
            end
            wftc_pkg::KIND_QUERY:
            begin
                keep  = 1'b1;
                op    = bad ? wftc_pkg::OP_BAD : wftc_pkg::OP_QUERY;
                pos_a = AW'(left_e);
            end
            wftc_pkg::KIND_CLEAR:
            begin
                keep = 1'b1;
                op   = wftc_pkg::OP_CLEAR;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign full   = q_full;
    assign q_push = push & keep & ~q_full;
    assign q_data = {op, pos_a, PW'(end_e), VAL_W'(val_c)};

endmodule

// ----- rtl/core/wftc_cmd_queue.sv -----
// ---------------------------------------------------------------------
// wftc_cmd_queue
// Short command queue decoupling the front from the back end.
// ---------------------------------------------------------------------
module wftc_cmd_queue #(
    parameter int DEPTH  = wftc_pkg::QUEUE_DEPTH,
    parameter int DATA_W = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  logic [DATA_W-1:0] wr_data,
    output logic              q_full,
    input  logic              rd_en,
    output logic              q_empty,
    output logic [DATA_W-1:0] rd_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_wr, do_rd;

    assign q_full  = count_reg == CNT_W'(DEPTH);
    assign q_empty = count_reg == '0;
    assign do_wr   = wr_en & ~q_full;
    assign do_rd   = rd_en & ~q_empty;
    assign rd_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ----- rtl/core/wftc_back.sv -----
// ---------------------------------------------------------------------
// wftc_back
// Executes commands: element store, histogram, window walk and the
// result register.
// ---------------------------------------------------------------------
module wftc_back #(
    parameter int ARRAY_DEPTH = wftc_pkg::DEF_ARRAY_DEPTH,
    parameter int VALUE_COUNT = wftc_pkg::DEF_VALUE_COUNT
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic [wftc_pkg::COUNT_W-1:0]            thr,
    input  logic                                    q_empty,
    input  logic [wftc_pkg::cmd_w(ARRAY_DEPTH, VALUE_COUNT)-1:0] q_data,
    output logic                                    q_pop,
    output logic                                    empty,
    input  logic                                    pop,
    output logic [wftc_pkg::COUNT_W-1:0]            qualifying_values,
    output logic                                    bad_query
);

    localparam int AW    = wftc_pkg::addr_w(ARRAY_DEPTH);
    localparam int PW    = AW + 1;
    localparam int VAL_W = wftc_pkg::addr_w(VALUE_COUNT);
    localparam int CW    = wftc_pkg::COUNT_W;
    localparam int CMD_W = wftc_pkg::cmd_w(ARRAY_DEPTH, VALUE_COUNT);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_WALK  = 3'd2;
    localparam logic [2:0] ST_ELEM  = 3'd3;
    localparam logic [2:0] ST_HIST  = 3'd4;

    // command fields
    wftc_pkg::op_t    cmd_op;
    logic [AW-1:0]    cmd_pos;
    logic [PW-1:0]    cmd_end;
    logic [VAL_W-1:0] cmd_val;

    assign cmd_op  = q_data[CMD_W-1 -: wftc_pkg::OP_W];
    assign cmd_pos = q_data[PW+VAL_W +: AW];
    assign cmd_end = q_data[VAL_W +: PW];
    assign cmd_val = q_data[VAL_W-1:0];

    logic [2:0]       state_reg, state_next;
    logic [VAL_W-1:0] clr_idx_reg, clr_idx_next;
    logic [PW-1:0]    win_start_reg, win_start_next;
    logic [PW-1:0]    win_end_reg, win_end_next;
    logic [CW-1:0]    qc_reg, qc_next;
    logic             res_valid_reg, res_valid_next;
    logic [CW-1:0]    res_count_reg, res_count_next;
    logic             res_bad_reg, res_bad_next;
    logic [AW-1:0]    q_left_reg, q_left_next;
    logic [PW-1:0]    q_end_reg, q_end_next;
    logic             op_add_reg, op_add_next;
    logic [VAL_W-1:0] val_reg, val_next;
    logic [VAL_W-1:0] elem_rd_reg;
    logic [CW-1:0]    hist_rd_reg;

    logic [VAL_W-1:0] elem_mem [ARRAY_DEPTH];
    logic [CW-1:0]    hist_mem [VALUE_COUNT];

    logic             elem_we;
    logic             hist_we;
    logic [VAL_W-1:0] hist_waddr;
    logic [CW-1:0]    hist_wdata;
    logic             slot_free;
    logic             res_set;
    logic [PW-1:0]    left_ext;
    logic [PW-1:0]    start_dec, end_dec;
    logic             grow_end, grow_start, shrink_end, shrink_start;
    logic [AW-1:0]    step_pos;
    logic [CW-1:0]    cnt_inc, cnt_dec;

    assign slot_free = ~res_valid_reg | pop;
    assign left_ext  = PW'(q_left_reg);
    assign start_dec = win_start_reg - PW'(1);
    assign end_dec   = win_end_reg - PW'(1);
    assign cnt_inc   = hist_rd_reg + CW'(1);
    assign cnt_dec   = hist_rd_reg - CW'(1);

    // edge order: grow end, grow start, shrink end, shrink start
    always_comb
    begin
        grow_end     = win_end_reg < q_end_reg;
        grow_start   = win_start_reg > left_ext;
        shrink_end   = win_end_reg > q_end_reg;
        shrink_start = win_start_reg < left_ext;
        if (grow_end)
        begin
            step_pos = win_end_reg[AW-1:0];
        end
        else if (grow_start)
        begin
            step_pos = start_dec[AW-1:0];
        end
        else if (shrink_end)
        begin
            step_pos = end_dec[AW-1:0];
        end
        else
        begin
            step_pos = win_start_reg[AW-1:0];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_idx_next   = clr_idx_reg;
        win_start_next = win_start_reg;
        win_end_next   = win_end_reg;
        qc_next        = qc_reg;
        q_left_next    = q_left_reg;
        q_end_next     = q_end_reg;
        op_add_next    = op_add_reg;
        val_next       = val_reg;
        res_count_next = res_count_reg;
        res_bad_next   = res_bad_reg;
        res_set        = 1'b0;
        q_pop          = 1'b0;
        elem_we        = 1'b0;
        hist_we        = 1'b0;
        hist_waddr     = val_reg;
        hist_wdata     = '0;

        case (state_reg)
            ST_CLEAR:
            begin
                hist_we      = 1'b1;
                hist_waddr   = clr_idx_reg;
                hist_wdata   = '0;
                clr_idx_next = clr_idx_reg + VAL_W'(1);
                if (clr_idx_reg == VAL_W'(VALUE_COUNT - 1))
                begin
                    clr_idx_next = '0;
                    state_next   = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    case (cmd_op)
                        wftc_pkg::OP_LOAD:
                        begin
                            q_pop   = 1'b1;
                            elem_we = 1'b1;
                        end
                        wftc_pkg::OP_CLEAR:
                        begin
                            q_pop          = 1'b1;
                            win_start_next = '0;
                            win_end_next   = '0;
                            qc_next        = '0;
                            state_next     = ST_CLEAR;
                        end
                        wftc_pkg::OP_QUERY:
                        begin
                            q_pop       = 1'b1;
                            q_left_next = cmd_pos;
                            q_end_next  = cmd_end;
                            state_next  = ST_WALK;
                        end
                        default:
                        begin
                            // bad range: answer without a walk, once the result slot is free
                            if (slot_free)
                            begin
                                q_pop          = 1'b1;
                                res_set        = 1'b1;
                                res_count_next = '0;
                                res_bad_next   = 1'b1;
                            end
                        end
                    endcase
                end
            end
            ST_WALK:
            begin
                if (grow_end || grow_start || shrink_end || shrink_start)
                begin
                    op_add_next = grow_end | grow_start;
                    state_next  = ST_ELEM;
                    if (grow_end)
                    begin
                        win_end_next = win_end_reg + PW'(1);
                    end
                    else if (grow_start)
                    begin
                        win_start_next = start_dec;
                    end
                    else if (shrink_end)
                    begin
                        win_end_next = end_dec;
                    end
                    else
                    begin
                        win_start_next = win_start_reg + PW'(1);
                    end
                end
                else if (slot_free)
                begin
                    res_set        = 1'b1;
                    res_count_next = qc_reg;
                    res_bad_next   = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            ST_ELEM:
            begin
                val_next   = elem_rd_reg;
                state_next = ST_HIST;
            end
            ST_HIST:
            begin
                state_next = ST_WALK;
                if (op_add_reg)
                begin
                    if (hist_rd_reg != wftc_pkg::CNT_MAX)
                    begin
                        hist_we    = 1'b1;
                        hist_wdata = cnt_inc;
                        if (cnt_inc == thr && qc_reg != wftc_pkg::CNT_MAX)
                        begin
                            qc_next = qc_reg + CW'(1);
                        end
                    end
                end
                else
                begin
                    if (hist_rd_reg != '0)
                    begin
                        hist_we    = 1'b1;
                        hist_wdata = cnt_dec;
                        if (hist_rd_reg == thr && qc_reg != '0)
                        begin
                            qc_next = qc_reg - CW'(1);
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        res_valid_next = res_set ? 1'b1 : (pop ? 1'b0 : res_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_idx_reg   <= '0;
            win_start_reg <= '0;
            win_end_reg   <= '0;
            qc_reg        <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_idx_reg   <= clr_idx_next;
            win_start_reg <= win_start_next;
            win_end_reg   <= win_end_next;
            qc_reg        <= qc_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_left_reg    <= q_left_next;
        q_end_reg     <= q_end_next;
        op_add_reg    <= op_add_next;
        val_reg       <= val_next;
        res_count_reg <= res_count_next;
        res_bad_reg   <= res_bad_next;
    end

    // element store: written by loads, read at the walking edge
    always_ff @(posedge clk)
    begin
        if (elem_we)
        begin
            elem_mem[cmd_pos] <= cmd_val;
        end
        elem_rd_reg <= elem_mem[step_pos];
    end

    // histogram: read at the fetched value, written back in the histogram state
    always_ff @(posedge clk)
    begin
        if (hist_we)
        begin
            hist_mem[hist_waddr] <= hist_wdata;
        end
        hist_rd_reg <= hist_mem[elem_rd_reg];
    end

    assign empty             = ~res_valid_reg;
    assign qualifying_values = res_count_reg;
    assign bad_query         = res_bad_reg;

    a_window_order: assert property (@(posedge clk) disable iff (!rst_n)
        win_start_reg <= win_end_reg)
        else $error("window start passed window end");

    a_window_bound: assert property (@(posedge clk) disable iff (!rst_n)
        win_end_reg <= PW'(ARRAY_DEPTH))
        else $error("window end beyond array");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        res_set |-> (!res_valid_reg || pop))
        else $error("result overwritten before it was taken");

    a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> (qc_reg == '0 && win_end_reg == '0))
        else $error("window not empty during clearing pass");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("command popped from empty queue");

endmodule

// ----- rtl/core/window_frequency_threshold_counter_unit.sv -----
// ---------------------------------------------------------------------
// window_frequency_threshold_counter_unit
// Requests enter with push/full; each is load, query or clear. Results
// (one per query) leave with empty/pop, oldest first, held until popped.
// Loads and clears give no result; a query with left above right gives
// bad_query with a zero count and leaves the window alone.
// The threshold register is written with threshold_we; the user must
// write it only while idle, which the block does not enforce; issue
// a clear after changing it. A request is registered in the command
// queue, and a load is done in the idle state. A query is taken in
// the idle state, then passes the walk, element and histogram states
// per element the window edges move (element read, histogram read,
// histogram write-back), then posts its result. A clear sweeps all
// VALUE_COUNT histogram entries; reset empties the window and does the
// same, while requests queue up until the queue is full. A result not
// popped holds the back end at the end of the next query.
// ---------------------------------------------------------------------
module window_frequency_threshold_counter_unit #(
    parameter int ARRAY_DEPTH = wftc_pkg::DEF_ARRAY_DEPTH,
    parameter int VALUE_COUNT = wftc_pkg::DEF_VALUE_COUNT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic [1:0]                     kind,
    input  logic [wftc_pkg::FIELD_W-1:0]   element_index,
    input  logic [wftc_pkg::FIELD_W-1:0]   element_value,
    input  logic [wftc_pkg::FIELD_W-1:0]   range_left,
    input  logic [wftc_pkg::FIELD_W-1:0]   range_right,
    output logic                           empty,
    input  logic                           pop,
    output logic [wftc_pkg::COUNT_W-1:0]   qualifying_values,
    output logic                           bad_query,
    input  logic                           threshold_we,
    input  logic [wftc_pkg::COUNT_W-1:0]   threshold
);

    localparam int CMD_W = wftc_pkg::cmd_w(ARRAY_DEPTH, VALUE_COUNT);

    logic [wftc_pkg::COUNT_W-1:0] threshold_reg, threshold_next;
    logic                         q_push, q_full, q_empty, q_pop;
    logic [CMD_W-1:0]             q_wdata, q_rdata;

    assign threshold_next = threshold_we ? threshold : threshold_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= wftc_pkg::COUNT_W'(1);
        end
        else
        begin
            threshold_reg <= threshold_next;
        end
    end

    wftc_front #(
        .ARRAY_DEPTH (ARRAY_DEPTH),
        .VALUE_COUNT (VALUE_COUNT)
    ) u_front (
        .push          (push),
        .full          (full),
        .kind          (kind),
        .element_index (element_index),
        .element_value (element_value),
        .range_left    (range_left),
        .range_right   (range_right),
        .q_push        (q_push),
        .q_full        (q_full),
        .q_data        (q_wdata)
    );

    wftc_cmd_queue #(
        .DEPTH  (wftc_pkg::QUEUE_DEPTH),
        .DATA_W (CMD_W)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (q_wdata),
        .q_full  (q_full),
        .rd_en   (q_pop),
        .q_empty (q_empty),
        .rd_data (q_rdata)
    );

    wftc_back #(
        .ARRAY_DEPTH (ARRAY_DEPTH),
        .VALUE_COUNT (VALUE_COUNT)
    ) u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .thr               (threshold_reg),
        .q_empty           (q_empty),
        .q_data            (q_rdata),
        .q_pop             (q_pop),
        .empty             (empty),
        .pop               (pop),
        .qualifying_values (qualifying_values),
        .bad_query         (bad_query)
    );

endmodule
